[rtl/tiered_idle_sleep_controller_core_defines.svh]
// Assertion macros shared by the checker.
`ifndef TIERED_IDLE_SLEEP_CONTROLLER_CORE_DEFINES_SVH
`define TIERED_IDLE_SLEEP_CONTROLLER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TISC_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("tisc check failed");

// Next-cycle implication, disabled while reset is asserted.
`define TISC_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("tisc check failed");

`endif

[rtl/tisc_pkg.sv]
package tisc_pkg;

    localparam int unsigned TIME_W  = 32;
    localparam int unsigned SONG_W  = 27;
    localparam int unsigned KIND_W  = 2;
    localparam int unsigned ACT_W   = 2;
    localparam int unsigned CFG_AW  = 4;
    localparam int unsigned CFG_DW  = 32;

    localparam logic [TIME_W-1:0] DAY_MS            = 32'd86400000;
    localparam logic [TIME_W-1:0] PRESS_GRACE_MS    = 32'd10000;
    localparam logic [SONG_W:0]   MIN_PLAY_SLEEP_MS = 28'd1000;

    localparam logic [KIND_W-1:0] KIND_PRESS     = 2'd0;
    localparam logic [KIND_W-1:0] KIND_PLAY      = 2'd1;
    localparam logic [KIND_W-1:0] KIND_TRANSPORT = 2'd2;
    localparam logic [KIND_W-1:0] KIND_TICK      = 2'd3;

    localparam logic [ACT_W-1:0] ACT_NONE  = 2'd0;
    localparam logic [ACT_W-1:0] ACT_LIGHT = 2'd1;
    localparam logic [ACT_W-1:0] ACT_DEEP  = 2'd2;

    localparam logic [1:0] REG_LIGHT_TIMEOUT = 2'd0;
    localparam logic [1:0] REG_DEEP_TIMEOUT  = 2'd1;
    localparam logic [1:0] REG_PLAY_DELAY    = 2'd2;
    localparam logic [1:0] REG_WAKE_MARGIN   = 2'd3;

    localparam logic [TIME_W-1:0] LIGHT_TIMEOUT_RST = 32'd30000;
    localparam logic [TIME_W-1:0] DEEP_TIMEOUT_RST  = 32'd300000;
    localparam logic [TIME_W-1:0] PLAY_DELAY_RST    = 32'd10000;
    localparam logic [SONG_W-1:0] WAKE_MARGIN_RST   = 27'd5000;

    typedef struct packed {
        logic [TIME_W-1:0] light_timeout_ms;
        logic [TIME_W-1:0] deep_timeout_ms;
        logic [TIME_W-1:0] play_delay_ms;
        logic [SONG_W-1:0] wakeup_margin_ms;
    } cfg_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [TIME_W-1:0] time_ms;
        logic              now_playing;
        logic              was_playing;
        logic              transport_valid;
        logic [SONG_W-1:0] song_length_ms;
        logic [SONG_W-1:0] position_ms;
    } item_t;

    typedef struct packed {
        logic [ACT_W-1:0]  action;
        logic [TIME_W-1:0] sleep_ms;
        logic              status;
    } result_t;

endpackage

[rtl/tisc_cfg.sv]
module tisc_cfg
    import tisc_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [CFG_AW-1:0] paddr,
    input  logic [CFG_DW-1:0] pwdata,
    output logic [CFG_DW-1:0] prdata,
    output cfg_t              cfg
);

    cfg_t       cfg_reg;
    logic       wr_en;
    logic [1:0] reg_sel;

    assign wr_en   = psel & penable & pwrite;
    assign reg_sel = paddr[3:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.light_timeout_ms <= LIGHT_TIMEOUT_RST;
            cfg_reg.deep_timeout_ms  <= DEEP_TIMEOUT_RST;
            cfg_reg.play_delay_ms    <= PLAY_DELAY_RST;
            cfg_reg.wakeup_margin_ms <= WAKE_MARGIN_RST;
        end else if (wr_en) begin
            unique case (reg_sel)
                REG_LIGHT_TIMEOUT: cfg_reg.light_timeout_ms <= pwdata;
                REG_DEEP_TIMEOUT:  cfg_reg.deep_timeout_ms  <= pwdata;
                REG_PLAY_DELAY:    cfg_reg.play_delay_ms    <= pwdata;
                REG_WAKE_MARGIN:   cfg_reg.wakeup_margin_ms <= pwdata[SONG_W-1:0];
            endcase
        end
    end

    always_comb begin
        unique case (reg_sel)
            REG_LIGHT_TIMEOUT: prdata = cfg_reg.light_timeout_ms;
            REG_DEEP_TIMEOUT:  prdata = cfg_reg.deep_timeout_ms;
            REG_PLAY_DELAY:    prdata = cfg_reg.play_delay_ms;
            REG_WAKE_MARGIN:   prdata = {{(CFG_DW-SONG_W){1'b0}}, cfg_reg.wakeup_margin_ms};
        endcase
    end

    assign cfg = cfg_reg;

endmodule

[rtl/tisc_step.sv]
module tisc_step
    import tisc_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    advance,
    input  cfg_t    cfg,
    input  item_t   item,
    output result_t result
);

    logic [TIME_W-1:0] last_press_reg, last_press_next;
    logic [TIME_W-1:0] play_start_reg, play_start_next;
    logic              pending_reg, pending_next;
    logic              in_play_reg, in_play_next;
    logic              in_light_reg, in_light_next;
    logic [SONG_W-1:0] song_len_reg, song_len_next;
    logic [SONG_W-1:0] song_pos_reg, song_pos_next;

    logic [TIME_W-1:0] idle;
    logic [TIME_W-1:0] since_play;
    logic [SONG_W+1:0] play_left;
    logic              play_long;
    logic              backwards;
    logic              huge_gap;
    logic              deep_due;
    logic              light_due;
    logic              play_arm;

    assign idle       = item.time_ms - last_press_reg;
    assign since_play = item.time_ms - play_start_reg;
    assign backwards  = item.time_ms < last_press_reg;
    assign huge_gap   = idle > DAY_MS;
    assign deep_due   = idle >= cfg.deep_timeout_ms;
    assign light_due  = (idle >= cfg.light_timeout_ms) && !in_light_reg;
    assign play_arm   = item.now_playing && pending_reg && !in_play_reg && !in_light_reg;

    // signed remainder of the song after the wake margin
    assign play_left = {2'b00, song_len_reg} - {2'b00, song_pos_reg}
                     - {2'b00, cfg.wakeup_margin_ms};
    assign play_long = !play_left[SONG_W+1] && (play_left[SONG_W:0] > MIN_PLAY_SLEEP_MS);

    always_comb begin
        last_press_next = last_press_reg;
        play_start_next = play_start_reg;
        pending_next    = pending_reg;
        in_play_next    = in_play_reg;
        in_light_next   = in_light_reg;
        song_len_next   = song_len_reg;
        song_pos_next   = song_pos_reg;
        result          = '0;

        unique case (item.kind)
            KIND_PRESS: begin
                last_press_next = item.time_ms;
                if (in_play_reg || in_light_reg) begin
                    in_play_next  = 1'b0;
                    in_light_next = 1'b0;
                    pending_next  = 1'b0;
                end
            end
            KIND_PLAY: begin
                if (item.now_playing && !item.was_playing) begin
                    play_start_next = item.time_ms;
                    pending_next    = 1'b1;
                    in_play_next    = 1'b0;
                end else if (item.was_playing && !item.now_playing) begin
                    pending_next = 1'b0;
                    in_play_next = 1'b0;
                end
            end
            KIND_TRANSPORT: begin
                if (item.transport_valid) begin
                    song_len_next = item.song_length_ms;
                    song_pos_next = item.position_ms;
                end
            end
            KIND_TICK: begin
                priority if (backwards || huge_gap) begin
                    last_press_next = item.time_ms;
                    result.status   = 1'b1;
                end else if (deep_due) begin
                    result.action = ACT_DEEP;
                end else if (light_due) begin
                    in_light_next   = 1'b1;
                    result.action   = ACT_LIGHT;
                    result.sleep_ms = cfg.deep_timeout_ms - idle;
                end else if (play_arm && (idle >= PRESS_GRACE_MS)
                             && (since_play >= cfg.play_delay_ms)) begin
                    // drop the pending play sleep whether or not one is ordered
                    pending_next = 1'b0;
                    if ((song_len_reg != '0) && play_long) begin
                        in_play_next    = 1'b1;
                        result.action   = ACT_LIGHT;
                        result.sleep_ms = {{(TIME_W-SONG_W-1){1'b0}}, play_left[SONG_W:0]};
                    end
                end else begin
                    result.action = ACT_NONE;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_press_reg <= '0;
            play_start_reg <= '0;
            pending_reg    <= 1'b0;
            in_play_reg    <= 1'b0;
            in_light_reg   <= 1'b0;
            song_len_reg   <= '0;
            song_pos_reg   <= '0;
        end else if (advance) begin
            last_press_reg <= last_press_next;
            play_start_reg <= play_start_next;
            pending_reg    <= pending_next;
            in_play_reg    <= in_play_next;
            in_light_reg   <= in_light_next;
            song_len_reg   <= song_len_next;
            song_pos_reg   <= song_pos_next;
        end
    end

endmodule

[rtl/tiered_idle_sleep_controller_core.sv]
// A request is held in the input register, then moved into the result register on m_*.
// Throughput: one request per cycle while m_tready does not stall; the input register and
// the result register both advance whenever the result register is empty or being drained.
// Reset (aresetn low, synchronous): clears all tracking state and both valid flags,
// and loads the registers with their default timeouts.
module tiered_idle_sleep_controller_core
    import tisc_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    // time_ms[31:0], now_playing[32], was_playing[33], transport_valid[34],
    // song_length_ms[61:35], position_ms[88:62], zero fill [95:89]
    input  logic [95:0]       s_tdata,
    // kind[1:0]
    input  logic [1:0]        s_tuser,
    output logic              m_tvalid,
    input  logic              m_tready,
    // action[1:0], sleep_ms[33:2], status[34], zero fill [39:35]
    output logic [39:0]       m_tdata,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [CFG_AW-1:0] paddr,
    input  logic [CFG_DW-1:0] pwdata,
    output logic [CFG_DW-1:0] prdata,
    output logic              pready
);

    cfg_t    cfg;
    item_t   in_item_reg, in_item_next;
    logic    in_valid_reg;
    result_t out_reg;
    result_t step_result;
    logic    out_valid_reg;
    logic    advance;

    assign pready = 1'b1;

    tisc_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    // move the held request into the result register when there is room
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_comb begin
        in_item_next.kind            = s_tuser;
        in_item_next.time_ms         = s_tdata[31:0];
        in_item_next.now_playing     = s_tdata[32];
        in_item_next.was_playing     = s_tdata[33];
        in_item_next.transport_valid = s_tdata[34];
        in_item_next.song_length_ms  = s_tdata[61:35];
        in_item_next.position_ms     = s_tdata[88:62];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_item_reg <= in_item_next;
        end
    end

    tisc_step u_step (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .cfg     (cfg),
        .item    (in_item_reg),
        .result  (step_result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_reg <= step_result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'b0, out_reg.status, out_reg.sleep_ms, out_reg.action};

endmodule

[rtl/tisc_checker.sv]
`include "tiered_idle_sleep_controller_core_defines.svh"

module tisc_checker
    import tisc_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata
);

    `TISC_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    `TISC_ASSERT_NOW(a_action_code, aclk, aresetn, m_tvalid, m_tdata[1:0] <= ACT_DEEP)
    `TISC_ASSERT_NOW(a_status_quiet, aclk, aresetn, m_tvalid && m_tdata[34], m_tdata[33:0] == 34'd0)
    `TISC_ASSERT_NOW(a_deep_forever, aclk, aresetn, m_tvalid && (m_tdata[1:0] == ACT_DEEP), m_tdata[33:2] == '0)

endmodule

bind tiered_idle_sleep_controller_core tisc_checker u_tisc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
